// ----- rtl/gn3d_pkg.sv -----
package gn3d_pkg;

  // fixed formats of the fields
  localparam int FRAC_BITS  = 16;
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = 8;
  localparam int BYTE_W     = 8;
  localparam int FREQ_W     = 24;
  localparam int POS_W      = 32;
  localparam int NOISE_W    = 19;
  localparam int GRAD_W     = 32;
  localparam int PROD_W     = POS_W + FREQ_W + 1;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd65536;

  // register stages from queue head to the output register
  localparam int PIPE_DEPTH = 11;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef logic signed [31:0] fx_t;

  localparam fx_t ONE = 32'sd1 <<< FRAC_BITS;

  typedef struct packed {
    op_t                     opcode;
    logic [IDX_W-1:0]        table_index;
    logic [BYTE_W-1:0]       table_value;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } gn3d_in_t;

  typedef struct packed {
    logic signed [NOISE_W-1:0] noise_value;
    logic signed [GRAD_W-1:0]  grad_x;
    logic signed [GRAD_W-1:0]  grad_y;
    logic signed [GRAD_W-1:0]  grad_z;
  } gn3d_out_t;

  // evaluate beat as held in the queue
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } eval_t;

  // permutation table write, fanned out to every table copy
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } tbl_wr_t;

  // trilinear blend coefficients
  typedef struct packed {
    fx_t a;
    fx_t b;
    fx_t c;
    fx_t d;
    fx_t e;
    fx_t f;
    fx_t g;
    fx_t h;
  } coef_t;

  // fixed-point product, floored back to FRAC_BITS fraction bits
  function automatic logic signed [47:0] mq(input fx_t a, input fx_t b);
    logic signed [63:0] p;
    p = a * b;
    return 48'(p >>> FRAC_BITS);
  endfunction

  // gradient component (-1, 0, +1) of one of the 16 directions
  function automatic logic signed [1:0] grad_axis(input logic [3:0] gi, input logic [1:0] axis);
    logic signed [1:0] gx, gy, gz;
    case (gi)
      4'd0:    begin gx = 2'sb01; gy = 2'sb01; gz = 2'sb00; end
      4'd1:    begin gx = 2'sb11; gy = 2'sb01; gz = 2'sb00; end
      4'd2:    begin gx = 2'sb01; gy = 2'sb11; gz = 2'sb00; end
      4'd3:    begin gx = 2'sb11; gy = 2'sb11; gz = 2'sb00; end
      4'd4:    begin gx = 2'sb01; gy = 2'sb00; gz = 2'sb01; end
      4'd5:    begin gx = 2'sb11; gy = 2'sb00; gz = 2'sb01; end
      4'd6:    begin gx = 2'sb01; gy = 2'sb00; gz = 2'sb11; end
      4'd7:    begin gx = 2'sb11; gy = 2'sb00; gz = 2'sb11; end
      4'd8:    begin gx = 2'sb00; gy = 2'sb01; gz = 2'sb01; end
      4'd9:    begin gx = 2'sb00; gy = 2'sb11; gz = 2'sb01; end
      4'd10:   begin gx = 2'sb00; gy = 2'sb01; gz = 2'sb11; end
      4'd11:   begin gx = 2'sb00; gy = 2'sb11; gz = 2'sb11; end
      4'd12:   begin gx = 2'sb01; gy = 2'sb01; gz = 2'sb00; end
      4'd13:   begin gx = 2'sb11; gy = 2'sb01; gz = 2'sb00; end
      4'd14:   begin gx = 2'sb00; gy = 2'sb11; gz = 2'sb01; end
      default: begin gx = 2'sb00; gy = 2'sb11; gz = 2'sb11; end
    endcase
    case (axis)
      2'd0:    return gx;
      2'd1:    return gy;
      default: return gz;
    endcase
  endfunction

  // multiply by a unit component
  function automatic fx_t sel(input logic signed [1:0] g, input fx_t v);
    if (g == 2'sb01) return v;
    else if (g == 2'sb11) return -v;
    else return '0;
  endfunction

  // corner values to blend coefficients
  function automatic coef_t coefs(input fx_t v0, input fx_t v1, input fx_t v2, input fx_t v3,
                                  input fx_t v4, input fx_t v5, input fx_t v6, input fx_t v7);
    coef_t k;
    k.a = v0;
    k.b = v1 - v0;
    k.c = v2 - v0;
    k.d = v4 - v0;
    k.e = v3 - v2 - v1 + v0;
    k.f = v5 - v4 - v1 + v0;
    k.g = v6 - v4 - v2 + v0;
    k.h = v7 - v6 - v5 + v4 - v3 + v2 + v1 - v0;
    return k;
  endfunction

endpackage

// ----- rtl/gn3d_ram.sv -----
module gn3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/gn3d_fifo.sv -----
module gn3d_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gn3d_pkg::eval_t push_data,
  input  logic           pop,
  output gn3d_pkg::eval_t pop_data,
  output logic           full,
  output logic           empty
);
  import gn3d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  eval_t           slots [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

// ----- rtl/gn3d_front.sv -----
module gn3d_front #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  gn3d_pkg::gn3d_in_t in_data,
  input  logic              q_full,
  output logic              push,
  output gn3d_pkg::eval_t   push_data,
  output gn3d_pkg::tbl_wr_t tbl_wr,
  input  logic              res_done
);
  import gn3d_pkg::*;

  localparam int PEND_W = $clog2(QUEUE_DEPTH + PIPE_DEPTH + 1);

  // evaluations accepted whose results are not yet delivered
  logic [PEND_W-1:0] pend;
  logic [PEND_W-1:0] pend_next;
  logic              fire;

  // a load waits until no evaluation is in flight, so it never overtakes a read
  assign in_stall = (in_data.opcode == OP_EVAL) ? q_full : (pend != '0);
  assign fire     = in_valid & ~in_stall;

  assign push            = fire & (in_data.opcode == OP_EVAL);
  assign push_data.pos_x = in_data.pos_x;
  assign push_data.pos_y = in_data.pos_y;
  assign push_data.pos_z = in_data.pos_z;

  assign tbl_wr.en   = fire & (in_data.opcode == OP_LOAD);
  assign tbl_wr.addr = in_data.table_index;
  assign tbl_wr.data = in_data.table_value;

  assign pend_next = pend + PEND_W'(push) - PEND_W'(res_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

endmodule

// ----- rtl/gn3d_interp.sv -----
module gn3d_interp (
  input  logic            clk,
  input  logic            en,
  input  gn3d_pkg::coef_t k,
  input  gn3d_pkg::fx_t   tx,
  input  gn3d_pkg::fx_t   ty,
  input  gn3d_pkg::fx_t   tz,
  output gn3d_pkg::fx_t   res
);
  import gn3d_pkg::*;

  // a + b*tx + (c + e*tx)*ty + (d + f*tx + (g + h*tx)*ty)*tz, three stages
  fx_t a1, c1, d1, g1, mb1, me1, mf1, mh1, ty1, tz1;
  fx_t p2, n12, u32, n22, tz2;

  always_ff @(posedge clk) begin
    if (en) begin
      // products with tx
      a1  <= k.a;
      c1  <= k.c;
      d1  <= k.d;
      g1  <= k.g;
      mb1 <= fx_t'(mq(k.b, tx));
      me1 <= fx_t'(mq(k.e, tx));
      mf1 <= fx_t'(mq(k.f, tx));
      mh1 <= fx_t'(mq(k.h, tx));
      ty1 <= ty;
      tz1 <= tz;
      // products with ty
      p2  <= a1 + mb1;
      u32 <= d1 + mf1;
      n12 <= fx_t'(mq(c1 + me1, ty1));
      n22 <= fx_t'(mq(g1 + mh1, ty1));
      tz2 <= tz1;
      // product with tz and final sum
      res <= p2 + n12 + fx_t'(mq(u32 + n22, tz2));
    end
  end

endmodule

// ----- rtl/gn3d_back.sv -----
module gn3d_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  gn3d_pkg::eval_t    q_data,
  output logic               q_pop,
  input  logic [23:0]        freq,
  input  gn3d_pkg::tbl_wr_t  tbl_wr,
  output logic               out_valid,
  input  logic               out_stall,
  output gn3d_pkg::gn3d_out_t out_data
);
  import gn3d_pkg::*;

  localparam fx_t NOISE_MAX = (32'sd1 <<< (NOISE_W - 1)) - 32'sd1;
  localparam fx_t NOISE_MIN = -NOISE_MAX - 32'sd1;
  localparam logic signed [47:0] GRAD_MAX = (48'sd1 <<< (GRAD_W - 1)) - 48'sd1;
  localparam logic signed [47:0] GRAD_MIN = -GRAD_MAX - 48'sd1;

  logic en;
  assign en    = ~out_valid | ~out_stall;
  assign q_pop = en & ~q_empty;

  // stage valid bits
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;

  // stage 1: scaled positions
  logic signed [PROD_W-1:0] prod [3];
  // stage 2..4: lattice coordinates, offsets and fade
  logic [IDX_W-1:0]     lat_cell [3];
  logic [FRAC_BITS-1:0] toff [3];
  fx_t t1w [3], tt1w [3], ia1w [3], ib1w [3];
  logic [IDX_W-1:0] c1_2, c2_2, c2_3;
  fx_t t2 [3], tt2 [3], ia2 [3], ib2 [3];
  fx_t t3 [3], ttt3 [3], ia3 [3], ds3 [3];
  fx_t t4 [3], s4 [3], ds4 [3];
  // stage 5, 6: corner values and coefficients
  fx_t        cv5 [8];
  logic [3:0] gi5 [8];
  fx_t        s5 [3], ds5 [3];
  coef_t      kv6;
  coef_t      kq6 [3];
  coef_t      kd6 [3];
  fx_t        s6 [3], ds6 [3];
  // blend results and tail
  fx_t ds7 [3], ds8 [3], ds9 [3];
  fx_t val9, der9 [3], dinn9 [3];
  fx_t val10, der10 [3], delta10 [3];

  // table copies: two for x, four for y, eight for z hashing
  logic [IDX_W-1:0]  hx_addr [2];
  logic [BYTE_W-1:0] hx_q    [2];
  logic [IDX_W-1:0]  hy_addr [4];
  logic [BYTE_W-1:0] hy_q    [4];
  logic [IDX_W-1:0]  hz_addr [8];
  logic [BYTE_W-1:0] hz_q    [8];

  for (genvar i = 0; i < 2; i++) begin : g_hx
    gn3d_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_SIZE)) u_ram (
      .clk(clk), .we(tbl_wr.en), .waddr(tbl_wr.addr), .wdata(tbl_wr.data),
      .re(en), .raddr(hx_addr[i]), .rdata(hx_q[i])
    );
  end
  for (genvar i = 0; i < 4; i++) begin : g_hy
    gn3d_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_SIZE)) u_ram (
      .clk(clk), .we(tbl_wr.en), .waddr(tbl_wr.addr), .wdata(tbl_wr.data),
      .re(en), .raddr(hy_addr[i]), .rdata(hy_q[i])
    );
  end
  for (genvar i = 0; i < 8; i++) begin : g_hz
    gn3d_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_SIZE)) u_ram (
      .clk(clk), .we(tbl_wr.en), .waddr(tbl_wr.addr), .wdata(tbl_wr.data),
      .re(en), .raddr(hz_addr[i]), .rdata(hz_q[i])
    );
  end

  // lattice cell (mod 256) and offset straight from the scaled position
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lat_cell[k] = prod[k][2*FRAC_BITS +: IDX_W];
      toff[k] = prod[k][FRAC_BITS +: FRAC_BITS];
      t1w[k]  = fx_t'(toff[k]);
      tt1w[k] = fx_t'(mq(t1w[k], t1w[k]));
      ia1w[k] = fx_t'(mq(t1w[k], 6 * t1w[k] - 15 * ONE)) + 10 * ONE;
      ib1w[k] = fx_t'(mq(t1w[k], t1w[k] - 2 * ONE)) + ONE;
    end
  end

  // hash addresses, one level per stage
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      hx_addr[i] = lat_cell[0] + IDX_W'(i);
    end
    for (int j = 0; j < 4; j++) begin
      hy_addr[j] = hx_q[j % 2] + c1_2 + IDX_W'(j / 2);
    end
    for (int n = 0; n < 8; n++) begin
      hz_addr[n] = hy_q[n % 4] + c2_3 + IDX_W'(n / 4);
    end
  end

  // corner dot products
  fx_t cv4 [8];
  always_comb begin
    for (int n = 0; n < 8; n++) begin
      cv4[n] = sel(grad_axis(hz_q[n][3:0], 2'd0), (n % 2 != 0) ? t4[0] - ONE : t4[0])
             + sel(grad_axis(hz_q[n][3:0], 2'd1), ((n / 2) % 2 != 0) ? t4[1] - ONE : t4[1])
             + sel(grad_axis(hz_q[n][3:0], 2'd2), (n / 4 != 0) ? t4[2] - ONE : t4[2]);
    end
  end

  // coefficients of the value and of the gradient-component fields
  coef_t kv5;
  coef_t kq5 [3];
  fx_t   qv [3][8];
  always_comb begin
    kv5 = coefs(cv5[0], cv5[1], cv5[2], cv5[3], cv5[4], cv5[5], cv5[6], cv5[7]);
    for (int k = 0; k < 3; k++) begin
      for (int n = 0; n < 8; n++) begin
        qv[k][n] = sel(grad_axis(gi5[n], 2'(k)), ONE);
      end
      kq5[k] = coefs(qv[k][0], qv[k][1], qv[k][2], qv[k][3],
                     qv[k][4], qv[k][5], qv[k][6], qv[k][7]);
    end
  end

  // blend inputs for the fade-derivative terms
  always_comb begin
    kd6[0] = '{a: kv6.b, b: kv6.e, c: '0, d: kv6.f, e: '0, f: kv6.h, g: '0, h: '0};
    kd6[1] = '{a: kv6.c, b: kv6.e, c: '0, d: kv6.g, e: '0, f: kv6.h, g: '0, h: '0};
    kd6[2] = '{a: kv6.d, b: kv6.f, c: '0, d: kv6.g, e: '0, f: kv6.h, g: '0, h: '0};
  end

  gn3d_interp u_val (
    .clk(clk), .en(en), .k(kv6), .tx(s6[0]), .ty(s6[1]), .tz(s6[2]), .res(val9)
  );
  for (genvar k = 0; k < 3; k++) begin : g_der
    gn3d_interp u_der (
      .clk(clk), .en(en), .k(kq6[k]), .tx(s6[0]), .ty(s6[1]), .tz(s6[2]), .res(der9[k])
    );
  end
  gn3d_interp u_dx (
    .clk(clk), .en(en), .k(kd6[0]), .tx(s6[1]), .ty(s6[1]), .tz(s6[2]), .res(dinn9[0])
  );
  gn3d_interp u_dy (
    .clk(clk), .en(en), .k(kd6[1]), .tx(s6[0]), .ty(s6[0]), .tz(s6[2]), .res(dinn9[1])
  );
  gn3d_interp u_dz (
    .clk(clk), .en(en), .k(kd6[2]), .tx(s6[0]), .ty(s6[0]), .tz(s6[1]), .res(dinn9[2])
  );

  // final scaling by frequency and saturation
  fx_t               freq_fx;
  logic signed [47:0] gsc [3];
  logic signed [GRAD_W-1:0] gsat [3];
  logic signed [NOISE_W-1:0] nsat;
  always_comb begin
    freq_fx = fx_t'({8'd0, freq});
    for (int k = 0; k < 3; k++) begin
      gsc[k] = mq(der10[k] + delta10[k], freq_fx);
      if (gsc[k] > GRAD_MAX) gsat[k] = GRAD_MAX[GRAD_W-1:0];
      else if (gsc[k] < GRAD_MIN) gsat[k] = GRAD_MIN[GRAD_W-1:0];
      else gsat[k] = gsc[k][GRAD_W-1:0];
    end
    if (val10 > NOISE_MAX) nsat = NOISE_MAX[NOISE_W-1:0];
    else if (val10 < NOISE_MIN) nsat = NOISE_MIN[NOISE_W-1:0];
    else nsat = val10[NOISE_W-1:0];
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10} <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= ~q_empty;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      v8        <= v7;
      v9        <= v8;
      v10       <= v9;
      out_valid <= v10;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= q_data.pos_x * $signed({1'b0, freq});
      prod[1] <= q_data.pos_y * $signed({1'b0, freq});
      prod[2] <= q_data.pos_z * $signed({1'b0, freq});
      c1_2 <= lat_cell[1];
      c2_2 <= lat_cell[2];
      c2_3 <= c2_2;
      for (int k = 0; k < 3; k++) begin
        t2[k]   <= t1w[k];
        tt2[k]  <= tt1w[k];
        ia2[k]  <= ia1w[k];
        ib2[k]  <= ib1w[k];
        t3[k]   <= t2[k];
        ttt3[k] <= fx_t'(mq(tt2[k], t2[k]));
        ia3[k]  <= ia2[k];
        ds3[k]  <= fx_t'(mq(30 * tt2[k], ib2[k]));
        t4[k]   <= t3[k];
        s4[k]   <= fx_t'(mq(ttt3[k], ia3[k]));
        ds4[k]  <= ds3[k];
        s5[k]   <= s4[k];
        ds5[k]  <= ds4[k];
        kq6[k]  <= kq5[k];
        s6[k]   <= s5[k];
        ds6[k]  <= ds5[k];
        ds7[k]  <= ds6[k];
        ds8[k]  <= ds7[k];
        ds9[k]  <= ds8[k];
        der10[k]   <= der9[k];
        delta10[k] <= fx_t'(mq(dinn9[k], ds9[k]));
      end
      for (int n = 0; n < 8; n++) begin
        cv5[n] <= cv4[n];
        gi5[n] <= hz_q[n][3:0];
      end
      kv6   <= kv5;
      val10 <= val9;
      out_data.noise_value <= nsat;
      out_data.grad_x      <= gsat[0];
      out_data.grad_y      <= gsat[1];
      out_data.grad_z      <= gsat[2];
    end
  end

endmodule

// ----- rtl/gradient_noise_3d_with_derivative.sv -----
// Throughput: one evaluate beat per cycle; the back pipeline stalls as a whole on out_stall.
// A load beat writes the permutation table at acceptance; it waits until every
// earlier evaluation has delivered its result.
// Reset clears the queue, pipeline valids and in-flight count, and sets frequency
// to 1.0; the permutation table is not cleared and must be loaded before use.
module gradient_noise_3d_with_derivative #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  gn3d_pkg::gn3d_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gn3d_pkg::gn3d_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [23:0]         cfg_data
);
  import gn3d_pkg::*;

  logic              push, pop, q_full, q_empty;
  eval_t             push_data, pop_data;
  tbl_wr_t           tbl_wr;
  logic [FREQ_W-1:0] frequency;

  // frequency register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frequency <= FREQ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frequency <= cfg_data;
    end
  end

  gn3d_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_full(q_full), .push(push), .push_data(push_data),
    .tbl_wr(tbl_wr), .res_done(out_valid & ~out_stall)
  );

  gn3d_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data),
    .full(q_full), .empty(q_empty)
  );

  gn3d_back u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_data(pop_data), .q_pop(pop),
    .freq(frequency), .tbl_wr(tbl_wr),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

// ----- rtl/gn3d_checker.sv -----
module gn3d_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input gn3d_pkg::gn3d_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input gn3d_pkg::gn3d_out_t out_data
);
  import gn3d_pkg::*;

  // evaluations accepted and not yet delivered
  logic [5:0] owed;
  logic       ev_in, res_out;

  assign ev_in   = in_valid & ~in_stall & (in_data.opcode == OP_EVAL);
  assign res_out = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else begin
      owed <= owed + 6'(ev_in) - 6'(res_out);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> owed != 6'd0)
    else $error("result beat without a pending evaluation");

  a_load_order: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_data.opcode == OP_LOAD && owed != 6'd0 |-> in_stall)
    else $error("load accepted while evaluations are in flight");

endmodule

bind gradient_noise_3d_with_derivative gn3d_checker u_checker (.*);
